/* hw/rtl/hid_keyboard_report_differ_macros.svh */
// ----------------------------------------------------------------------------
// hid keyboard report differ assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef HID_KEYBOARD_REPORT_DIFFER_MACROS_SVH
`define HID_KEYBOARD_REPORT_DIFFER_MACROS_SVH

`ifndef SYNTHESIS
`define HKRD_ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hkrd assertion failed");
`define HKRD_ASSERT(label, prop) \
  `HKRD_ASSERT_CLK(label, clk_i, rst_ni, prop)
`else
`define HKRD_ASSERT_CLK(label, clk, rst_n, prop)
`define HKRD_ASSERT(label, prop)
`endif

`endif

/* hw/rtl/hkrd_pkg.sv */
// ----------------------------------------------------------------------------
// hkrd_pkg
// shared constants and types of the keyboard report differ
// ----------------------------------------------------------------------------
package hkrd_pkg;

  localparam int KEY_SLOT_COUNT = 6;
  localparam int INPUT_SLOTS    = 6;
  localparam int KEY_W          = 8;
  localparam int MOD_BITS       = 8;
  localparam int EVENT_COUNT    = MOD_BITS + 2 * KEY_SLOT_COUNT;

  localparam int IN_SLOTS_W     = INPUT_SLOTS * KEY_W;
  localparam int IN_TDATA_W     = ((MOD_BITS + IN_SLOTS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W    = KEY_W;

  localparam int PADDR_W        = 3;
  localparam int PDATA_W        = 32;

  // register index, taken from paddr[2]
  localparam logic REG_MOD_BASE = 1'b0;

  localparam logic [KEY_W-1:0] MOD_BASE_RESET = 8'd224;

  typedef logic [KEY_SLOT_COUNT-1:0][KEY_W-1:0] key_slots_t;

  typedef struct packed {
    logic [EVENT_COUNT-1:0]            mask;
    logic [EVENT_COUNT-1:0][KEY_W-1:0] code;
    logic [EVENT_COUNT-1:0]            press;
  } event_set_t;

endpackage

/* hw/rtl/hkrd_diff.sv */
// ----------------------------------------------------------------------------
// hkrd_diff
// compares one report with the stored one and lays out all candidate events
// in emission order: modifier bits, then presses, then releases
// ----------------------------------------------------------------------------
module hkrd_diff (
  input  logic [hkrd_pkg::MOD_BITS-1:0]   mods_i,
  input  logic [hkrd_pkg::IN_SLOTS_W-1:0] keys_i,
  input  logic [hkrd_pkg::MOD_BITS-1:0]   prev_mods_i,
  input  hkrd_pkg::key_slots_t            prev_keys_i,
  input  logic [hkrd_pkg::KEY_W-1:0]      mod_base_i,
  output hkrd_pkg::key_slots_t            cur_keys_o,
  output hkrd_pkg::event_set_t            events_o
);

  localparam int K = hkrd_pkg::KEY_SLOT_COUNT;
  localparam int M = hkrd_pkg::MOD_BITS;

  hkrd_pkg::key_slots_t cur;
  logic [K-1:0] hit_prev;
  logic [K-1:0] hit_cur;

  for (genvar s = 0; s < K; s++) begin : g_slot
    if (s < hkrd_pkg::INPUT_SLOTS) begin : g_in
      assign cur[s] = keys_i[s*hkrd_pkg::KEY_W +: hkrd_pkg::KEY_W];
    end else begin : g_empty
      assign cur[s] = '0;
    end
  end

  assign cur_keys_o = cur;

  // cross compare of current and previous slots
  always_comb begin
    for (int s = 0; s < K; s++) begin
      hit_prev[s] = 1'b0;
      hit_cur[s]  = 1'b0;
      for (int j = 0; j < K; j++) begin
        if (prev_keys_i[j] == cur[s]) hit_prev[s] = 1'b1;
        if (cur[j] == prev_keys_i[s]) hit_cur[s] = 1'b1;
      end
    end
  end

  always_comb begin
    events_o = '0;
    for (int i = 0; i < M; i++) begin
      events_o.mask[i]  = mods_i[i] ^ prev_mods_i[i];
      events_o.code[i]  = mod_base_i + hkrd_pkg::KEY_W'(i);
      events_o.press[i] = mods_i[i];
    end
    for (int s = 0; s < K; s++) begin
      events_o.mask[M+s]    = (cur[s] != '0) && !hit_prev[s];
      events_o.code[M+s]    = cur[s];
      events_o.press[M+s]   = 1'b1;
      events_o.mask[M+K+s]  = (prev_keys_i[s] != '0) && !hit_cur[s];
      events_o.code[M+K+s]  = prev_keys_i[s];
      events_o.press[M+K+s] = 1'b0;
    end
  end

endmodule

/* hw/rtl/hid_keyboard_report_differ.sv */
// the first event of a report passes the event queue register, then the output register
// throughput: one event per cycle unless m_axis_tready stalls the output
// a report that causes no event leaves the queue empty; the next report is taken in the cycle
// the last event of the previous one moves into the output register
// reset: stored report cleared to zero, modifier base back to 224, no event pending
// ----------------------------------------------------------------------------
// hid_keyboard_report_differ
// turns boot keyboard reports into a stream of press and release events
// ----------------------------------------------------------------------------
`include "hid_keyboard_report_differ_macros.svh"

module hid_keyboard_report_differ (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // report stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [7:0] modifiers, [55:8] key_slots
  input  logic [hkrd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // event stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [7:0] keycode
  output logic [hkrd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // [0] is_press
  output logic [0:0]                        m_axis_tuser,
  output logic                              m_axis_tlast,
  // register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [hkrd_pkg::PADDR_W-1:0]      paddr,
  input  logic [hkrd_pkg::PDATA_W-1:0]      pwdata,
  output logic [hkrd_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready
);

  localparam int E  = hkrd_pkg::EVENT_COUNT;
  localparam int KW = hkrd_pkg::KEY_W;

  logic [KW-1:0]                   mod_base_q;
  logic [hkrd_pkg::MOD_BITS-1:0]   prev_mods_q;
  hkrd_pkg::key_slots_t            prev_keys_q;

  logic [E-1:0]                    pend_mask_q, pend_mask_d;
  logic [E-1:0][KW-1:0]            pend_code_q;
  logic [E-1:0]                    pend_press_q;

  logic                            m_valid_q, m_valid_d;
  logic [KW-1:0]                   m_code_q;
  logic                            m_press_q;
  logic                            m_last_q;

  hkrd_pkg::key_slots_t            cur_keys;
  hkrd_pkg::event_set_t            events;

  logic [E-1:0]                    sel_oh;
  logic [E-1:0]                    mask_after;
  logic [KW-1:0]                   sel_code;
  logic                            sel_press;
  logic                            out_load;
  logic                            in_accept;
  logic                            cfg_write;

  // ---------------------------------------------------------------- config
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    if (paddr[2] == hkrd_pkg::REG_MOD_BASE) begin
      prdata[KW-1:0] = mod_base_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_base_q <= hkrd_pkg::MOD_BASE_RESET;
    end else if (cfg_write && (paddr[2] == hkrd_pkg::REG_MOD_BASE)) begin
      mod_base_q <= pwdata[KW-1:0];
    end
  end

  // ---------------------------------------------------------------- diff
  hkrd_diff u_diff (
    .mods_i      (s_axis_tdata[hkrd_pkg::MOD_BITS-1:0]),
    .keys_i      (s_axis_tdata[hkrd_pkg::MOD_BITS +: hkrd_pkg::IN_SLOTS_W]),
    .prev_mods_i (prev_mods_q),
    .prev_keys_i (prev_keys_q),
    .mod_base_i  (mod_base_q),
    .cur_keys_o  (cur_keys),
    .events_o    (events)
  );

  // ---------------------------------------------------------------- event queue
  // lowest pending event goes next
  assign sel_oh = pend_mask_q & (~pend_mask_q + E'(1));

  always_comb begin
    sel_code  = '0;
    sel_press = 1'b0;
    for (int i = 0; i < E; i++) begin
      sel_code  = sel_code | (pend_code_q[i] & {KW{sel_oh[i]}});
      sel_press = sel_press | (pend_press_q[i] & sel_oh[i]);
    end
  end

  assign out_load   = (pend_mask_q != '0) && (!m_valid_q || m_axis_tready);
  assign mask_after = out_load ? (pend_mask_q & ~sel_oh) : pend_mask_q;

  assign s_axis_tready = (mask_after == '0);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  assign pend_mask_d = in_accept ? events.mask : mask_after;

  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_mask_q <= '0;
      m_valid_q   <= 1'b0;
      prev_mods_q <= '0;
      prev_keys_q <= '0;
    end else begin
      pend_mask_q <= pend_mask_d;
      m_valid_q   <= m_valid_d;
      if (in_accept) begin
        prev_mods_q <= s_axis_tdata[hkrd_pkg::MOD_BITS-1:0];
        prev_keys_q <= cur_keys;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pend_code_q  <= events.code;
      pend_press_q <= events.press;
    end
    if (out_load) begin
      m_code_q  <= sel_code;
      m_press_q <= sel_press;
      m_last_q  <= ((pend_mask_q & ~sel_oh) == '0);
    end
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = m_code_q;
  assign m_axis_tuser[0] = m_press_q;
  assign m_axis_tlast    = m_last_q;

  // ---------------------------------------------------------------- checks
  `HKRD_ASSERT(a_events_queued,
      (in_accept && (events.mask != '0)) |=> (pend_mask_q != '0))
  `HKRD_ASSERT(a_one_event_per_pop,
      (out_load && !in_accept) |=>
      ($countones(pend_mask_q) == $countones($past(pend_mask_q)) - 1))
  `HKRD_ASSERT(a_prev_mods_stored,
      in_accept |=> (prev_mods_q == $past(s_axis_tdata[hkrd_pkg::MOD_BITS-1:0])))

endmodule

/* bench/tb_hid_keyboard_report_differ.sv */
// ----------------------------------------------------------------------------
// tb_hid_keyboard_report_differ
// drives keyboard reports into the differ and checks every key event against
// a behavioral predictor; covers directed corner reports, modifier base
// writes and random report sequences with random gaps and output stalls
// ----------------------------------------------------------------------------
module tb_hid_keyboard_report_differ;
  timeunit 1ns;
  timeprecision 1ps;

  import hkrd_pkg::*;

  localparam logic [PADDR_W-1:0] ADDR_MOD_BASE = {REG_MOD_BASE, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_UNMAPPED = 3'd4;
  localparam int STALL_MAX      = 7;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int PHASE_REPORTS  = 100;
  localparam int PHASE_COUNT    = 4;
  localparam int PRINT_LIMIT    = 50;

  typedef struct packed {
    logic [KEY_W-1:0] keycode;
    logic             is_press;
    logic             last;
  } key_event_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // [7:0] modifiers, [55:8] key_slots
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b1;
  // [7:0] keycode
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  // [0] is_press
  logic [0:0]            m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [PADDR_W-1:0]    paddr = '0;
  logic [PDATA_W-1:0]    pwdata = '0;
  logic [PDATA_W-1:0]    prdata;
  logic                  pready;

  // predictor state
  logic [KEY_W-1:0]      mod_base = MOD_BASE_RESET;
  logic [MOD_BITS-1:0]   held_mods = '0;
  key_slots_t            held_keys = '0;
  key_event_t            pending_events[$];

  int  error_count = 0;
  int  idle_cycles = 0;
  bit  no_idle = 1'b0;

  hid_keyboard_report_differ dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    error_count++;
    if (error_count <= PRINT_LIMIT) begin
      $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
    end
  endtask

  function automatic bit slots_contain(input key_slots_t keys, input logic [KEY_W-1:0] code);
    for (int j = 0; j < KEY_SLOT_COUNT; j++) begin
      if (keys[j] == code) return 1'b1;
    end
    return 1'b0;
  endfunction

  // events a report causes against the held report, then the report is held
  function automatic void predict_key_events(input logic [MOD_BITS-1:0] mods,
                                             input key_slots_t keys);
    key_event_t evs[$];
    key_event_t ev;
    for (int i = 0; i < MOD_BITS; i++) begin
      if (mods[i] != held_mods[i]) begin
        ev.keycode  = mod_base + 8'(i);
        ev.is_press = mods[i];
        ev.last     = 1'b0;
        evs.push_back(ev);
      end
    end
    for (int i = 0; i < KEY_SLOT_COUNT; i++) begin
      if (keys[i] != '0 && !slots_contain(held_keys, keys[i])) begin
        ev.keycode  = keys[i];
        ev.is_press = 1'b1;
        ev.last     = 1'b0;
        evs.push_back(ev);
      end
    end
    for (int i = 0; i < KEY_SLOT_COUNT; i++) begin
      if (held_keys[i] != '0 && !slots_contain(keys, held_keys[i])) begin
        ev.keycode  = held_keys[i];
        ev.is_press = 1'b0;
        ev.last     = 1'b0;
        evs.push_back(ev);
      end
    end
    if (evs.size() > 0) evs[evs.size()-1].last = 1'b1;
    foreach (evs[k]) pending_events.push_back(evs[k]);
    held_mods = mods;
    held_keys = keys;
  endfunction

  // tvalid stays high into the next report when no gap is drawn
  task automatic drive_report(input logic [MOD_BITS-1:0] mods, input key_slots_t keys);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, STALL_MAX);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {keys, mods};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_key_events(mods, keys);
  endtask

  // block idle: every event out, then a settle wait for reports with no event
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [KEY_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {{(PDATA_W-KEY_W){1'b0}}, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr[PADDR_W-1:2] == REG_MOD_BASE) mod_base = value;
  endtask

  task automatic apb_read_check();
    logic [PDATA_W-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_MOD_BASE;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got[KEY_W-1:0] !== mod_base) report_mismatch("modifier base readback",
                                                     got[KEY_W-1:0], mod_base);
  endtask

  function automatic logic [MOD_BITS-1:0] next_mods();
    case ($urandom_range(0, 3))
      0:       return held_mods;
      1:       return held_mods ^ (8'd1 << $urandom_range(0, MOD_BITS-1));
      2:       return held_mods ^ 8'($urandom) ^ 8'($urandom);
      default: return 8'($urandom);
    endcase
  endfunction

  // mostly edits of the held report from a small key pool so keys overlap,
  // sometimes the same keys, sometimes raw noise
  function automatic key_slots_t next_keys();
    key_slots_t keys;
    int mode;
    keys = held_keys;
    mode = $urandom_range(0, 9);
    if (mode >= 8) begin
      keys = {16'($urandom), $urandom};
    end else if (mode < 6) begin
      for (int i = 0; i < KEY_SLOT_COUNT; i++) begin
        case ($urandom_range(0, 3))
          0:       keys[i] = '0;
          1:       keys[i] = 8'($urandom_range(4, 12));
          default: keys[i] = held_keys[i];
        endcase
      end
    end
    return keys;
  endfunction

  task automatic test_directed_reports();
    drive_report(8'h00, 48'h00_00_00_00_00_00);  // unchanged after reset
    drive_report(8'h01, 48'h00_00_00_00_00_04);
    drive_report(8'h01, 48'h00_00_00_00_00_04);  // unchanged
    drive_report(8'hFF, 48'h06_05_04_03_02_01);
    drive_report(8'h00, 48'h0C_0B_0A_09_08_07);  // every event at once
    drive_report(8'h00, 48'h00_00_FF_FF_FF_0B);  // repeated key
    drive_report(8'h00, 48'h00_00_00_00_00_00);  // repeated release
    drive_report(8'h80, 48'hFF_FF_FF_FF_FF_FF);
    drive_report(8'h7F, 48'h00_00_00_00_00_00);
    drive_report(8'h00, 48'h01_00_00_00_00_00);
    drive_report(8'h00, 48'h00_00_00_00_00_01);  // key moved to another slot
    drive_report(8'hAA, 48'hAA_AA_AA_AA_AA_AA);
    drive_report(8'h55, 48'h55_55_55_55_55_55);
    drive_report(8'h00, 48'h00_00_00_00_00_00);
  endtask

  task automatic test_modifier_base();
    wait_drained();
    apb_write(ADDR_MOD_BASE, 8'd250);  // keycodes wrap past 255
    apb_read_check();
    drive_report(8'hFF, '0);
    drive_report(8'h00, '0);
    wait_drained();
    apb_write(ADDR_MOD_BASE, 8'd0);
    apb_read_check();
    drive_report(8'h0F, '0);
    drive_report(8'h00, '0);
    wait_drained();
    apb_write(ADDR_MOD_BASE, 8'd255);
    apb_read_check();
    drive_report(8'hFF, '0);
    drive_report(8'h00, '0);
    wait_drained();
    apb_write(ADDR_UNMAPPED, 8'h11);  // no register here, base must hold
    apb_read_check();
    drive_report(8'h03, '0);
    drive_report(8'h00, '0);
  endtask

  task automatic test_random_reports();
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      wait_drained();
      apb_write(ADDR_MOD_BASE, (phase == 0) ? MOD_BASE_RESET : 8'($urandom));
      apb_read_check();
      for (int n = 0; n < PHASE_REPORTS; n++) begin
        if (n % 25 == 0) no_idle = ($urandom_range(0, 3) == 0);
        drive_report(next_mods(), next_keys());
      end
    end
    no_idle = 1'b0;
  endtask

  // output side: random stall before each beat
  initial begin : event_sink
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, STALL_MAX);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk_i) begin : event_check
    key_event_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_events.size() == 0) begin
        report_mismatch("event with none expected", m_axis_tdata, 8'h00);
      end else begin
        want = pending_events.pop_front();
        if (m_axis_tdata !== want.keycode)
          report_mismatch("keycode", m_axis_tdata, want.keycode);
        if (m_axis_tuser[0] !== want.is_press)
          report_mismatch("is_press", 8'(m_axis_tuser[0]), 8'(want.is_press));
        if (m_axis_tlast !== want.last)
          report_mismatch("last", 8'(m_axis_tlast), 8'(want.last));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_reports();
    test_modifier_base();
    test_random_reports();
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* hid_keyboard_report_differ.f */
+incdir+hw/rtl
hw/rtl/hkrd_pkg.sv
hw/rtl/hkrd_diff.sv
hw/rtl/hid_keyboard_report_differ.sv
bench/tb_hid_keyboard_report_differ.sv
